[hdl/frml_pkg.sv]
package frml_pkg;

  localparam int TS_W        = 32;
  localparam int IVL_W       = 16;
  localparam int Q_W         = 24;
  localparam int CAP_W       = 10;
  localparam int DELAY_W     = 10;
  localparam int DEN_W       = 24;

  // 1000 ms per second in Q10.16, divided by the average interval in Q16.8, gives fps in Q16.8.
  localparam int FPS_DIVIDEND = 65536000;
  localparam int FPS_DVD_W    = 26;
  localparam int MS_PER_S     = 1000;
  localparam int DEFAULT_FPS  = 60;
  localparam int DEFAULT_FPS_Q8 = DEFAULT_FPS * 256;

  localparam logic [IVL_W-1:0] INTERVAL_MAX = '1;
  localparam logic [Q_W-1:0]   OUT24_MAX    = '1;

endpackage

[hdl/frml_if.sv]
interface frml_in_if import frml_pkg::*;;
  logic            valid;
  logic            ready;
  logic [TS_W-1:0] start_ms;
  logic [TS_W-1:0] end_ms;

  modport source (output valid, output start_ms, output end_ms, input ready);
  modport sink   (input valid, input start_ms, input end_ms, output ready);
endinterface

interface frml_out_if import frml_pkg::*;;
  logic               valid;
  logic               ready;
  logic [Q_W-1:0]     fps_q8;
  logic [Q_W-1:0]     avg_interval_q8;
  logic [DELAY_W-1:0] delay_ms;

  modport source (output valid, output fps_q8, output avg_interval_q8, output delay_ms,
                  input ready);
  modport sink   (input valid, input fps_q8, input avg_interval_q8, input delay_ms,
                  output ready);
endinterface

[hdl/frame_rate_meter_limiter.sv]
// Channel     Direction  Payload                                  Transfer
// frame_in    in         start_ms, end_ms (32 b each)             valid & ready
// result_out  out        fps_q8, avg_interval_q8 (24 b), delay_ms valid & ready
// cfg         in         max_fps (10 b) on cfg_wdata              cfg_wen
//
// The shared bit-serial divider works on DVD_W = max($clog2(WINDOW) + 24, 26) bits
// and runs the average, the rate and the cap period of each frame one after another.
// The rate division is skipped when the average is zero.
// Reset needs no clearing pass: ring entries are only read once the ring is full.
// A finished result waits in the output register; the next frame is taken meanwhile.
module frame_rate_meter_limiter import frml_pkg::*; #(
  parameter int WINDOW = 100
) (
  input  logic             clk,
  input  logic             rst,
  frml_in_if.sink          frame_in,
  frml_out_if.source       result_out,
  input  logic             cfg_wen,
  input  logic [CAP_W-1:0] cfg_wdata
);

  localparam int ADDR_W = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = ADDR_W + IVL_W;
  localparam int DVD_W  = (SUM_W + 8 > FPS_DVD_W) ? SUM_W + 8 : FPS_DVD_W;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SUM   = 9'b000000010,
    S_AVG   = 9'b000000100,
    S_AVG_W = 9'b000001000,
    S_FPS   = 9'b000010000,
    S_FPS_W = 9'b000100000,
    S_PER   = 9'b001000000,
    S_PER_W = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t              state, state_next;
  logic [CAP_W-1:0]    max_fps;
  logic [TS_W-1:0]     prev_end;
  logic                seen_first;
  logic [IVL_W-1:0]    interval;
  logic [TS_W-1:0]     duration;
  logic [SUM_W-1:0]    sum;
  logic [CNT_W-1:0]    count;
  logic [ADDR_W-1:0]   slot;
  logic [Q_W-1:0]      avg_q;
  logic [Q_W-1:0]      fps_q;
  logic [DELAY_W-1:0]  delay_q;
  logic                out_valid;
  logic [Q_W-1:0]      out_fps;
  logic [Q_W-1:0]      out_avg;
  logic [DELAY_W-1:0]  out_delay;

  logic                accept;
  logic [TS_W-1:0]     gap;
  logic [IVL_W-1:0]    gap_sat;
  logic [IVL_W-1:0]    ring_rd;
  logic [IVL_W-1:0]    oldest;
  logic                ring_full;
  logic [CAP_W-1:0]    cap;
  logic [CAP_W-1:0]    period;
  logic                div_start;
  logic [DVD_W-1:0]    div_dvd;
  logic [DEN_W-1:0]    div_den;
  logic                div_done;
  logic [DVD_W-1:0]    div_quo;
  logic                out_load;

  assign frame_in.ready = (state == S_IDLE);
  assign accept         = frame_in.valid && frame_in.ready;

  assign gap     = frame_in.end_ms - prev_end;
  assign gap_sat = !seen_first ? '0 : ((|gap[TS_W-1:IVL_W]) ? INTERVAL_MAX : gap[IVL_W-1:0]);

  assign ring_full = (count == CNT_W'(WINDOW));
  // Until the ring is full, the slot being replaced was never written, so zero stands in for it.
  assign oldest    = ring_full ? ring_rd : '0;
  assign cap       = (max_fps == '0) ? CAP_W'(DEFAULT_FPS) : max_fps;
  assign period    = div_quo[CAP_W-1:0];
  assign out_load  = (state == S_OUT) && (!out_valid || result_out.ready);

  frml_ring #(.DEPTH(WINDOW)) u_ring (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (slot),
    .rd_data (ring_rd),
    .wr_en   (state == S_SUM),
    .wr_addr (slot),
    .wr_data (interval)
  );

  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_den   = '0;
    unique case (state)
      S_AVG: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'({sum, 8'h00});
        div_den   = DEN_W'(count);
      end
      S_FPS: begin
        div_start = (avg_q != '0);
        div_dvd   = DVD_W'(FPS_DIVIDEND);
        div_den   = avg_q;
      end
      S_PER: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'(MS_PER_S);
        div_den   = DEN_W'(cap);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  frml_div #(.DVD_W(DVD_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_SUM;
      S_SUM:   state_next = S_AVG;
      S_AVG:   state_next = S_AVG_W;
      S_AVG_W: if (div_done) state_next = S_FPS;
      S_FPS:   state_next = (avg_q != '0) ? S_FPS_W : S_PER;
      S_FPS_W: if (div_done) state_next = S_PER;
      S_PER:   state_next = S_PER_W;
      S_PER_W: if (div_done) state_next = S_OUT;
      S_OUT:   if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      max_fps    <= '0;
      prev_end   <= '0;
      seen_first <= 1'b0;
      sum        <= '0;
      count      <= '0;
      slot       <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        max_fps <= cfg_wdata;
      end
      if (accept) begin
        prev_end   <= frame_in.end_ms;
        seen_first <= 1'b1;
      end
      if (state == S_SUM) begin
        sum  <= sum - SUM_W'(oldest) + SUM_W'(interval);
        slot <= (slot == ADDR_W'(WINDOW - 1)) ? '0 : slot + 1'b1;
        if (!ring_full) begin
          count <= count + 1'b1;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      interval <= gap_sat;
      duration <= frame_in.end_ms - frame_in.start_ms;
    end
    if (state == S_AVG_W && div_done) begin
      avg_q <= div_quo[Q_W-1:0];
    end
    if (state == S_FPS) begin
      fps_q <= Q_W'(DEFAULT_FPS_Q8);
    end else if (state == S_FPS_W && div_done) begin
      fps_q <= (|div_quo[DVD_W-1:Q_W]) ? OUT24_MAX : div_quo[Q_W-1:0];
    end
    if (state == S_PER_W && div_done) begin
      delay_q <= (TS_W'(period) > duration) ? period - duration[DELAY_W-1:0] : '0;
    end
    if (out_load) begin
      out_fps   <= fps_q;
      out_avg   <= avg_q;
      out_delay <= delay_q;
    end
  end

  assign result_out.valid           = out_valid;
  assign result_out.fps_q8          = out_fps;
  assign result_out.avg_interval_q8 = out_avg;
  assign result_out.delay_ms        = out_delay;

endmodule

[hdl/frml_div.sv]
module frml_div import frml_pkg::*; #(
  parameter int DVD_W = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] work;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_diff;
  logic             fits;

  // Restoring division: one quotient bit a cycle, shifted in where the
  // dividend bits leave.
  assign rem_sh   = {rem, work[DVD_W-1]};
  assign rem_diff = rem_sh - {1'b0, den};
  assign fits     = rem_sh >= {1'b0, den};
  assign quotient = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      den  <= divisor;
    end else if (busy) begin
      work <= {work[DVD_W-2:0], fits};
      rem  <= fits ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

endmodule

[hdl/frml_ring.sv]
module frml_ring import frml_pkg::*; #(
  parameter int DEPTH = 100
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [IVL_W-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [IVL_W-1:0]         wr_data
);

  logic [IVL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/frml_chk.sv]
module frml_chk import frml_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [Q_W-1:0]     fps_q8,
  input logic [Q_W-1:0]     avg_interval_q8,
  input logic [DELAY_W-1:0] delay_ms
);

  // A result that is not taken stays, unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(fps_q8) && $stable(avg_interval_q8)
      && $stable(delay_ms))
    else $error("result changed or vanished before its transfer");

  // Once a frame is accepted, ready drops while that frame is in progress.
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("frame accepted while the previous one is in progress");

  a_delay_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> delay_ms <= DELAY_W'(MS_PER_S))
    else $error("delay beyond one second");

  a_zero_avg: assert property (@(posedge clk) disable iff (rst)
    out_valid && avg_interval_q8 == '0 |-> fps_q8 == Q_W'(DEFAULT_FPS_Q8))
    else $error("zero average interval without the default rate");

endmodule

bind frame_rate_meter_limiter frml_chk u_frml_chk (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (frame_in.valid),
  .in_ready        (frame_in.ready),
  .out_valid       (result_out.valid),
  .out_ready       (result_out.ready),
  .fps_q8          (result_out.fps_q8),
  .avg_interval_q8 (result_out.avg_interval_q8),
  .delay_ms        (result_out.delay_ms)
);

[bench/tb_frame_rate_meter_limiter.sv]
module tb_frame_rate_meter_limiter;
  import frml_pkg::*;

  localparam int WINDOW           = 100;
  localparam int PHASES           = 6;
  localparam int RANDOM_PER_PHASE = 200;
  localparam int STILL_FRAMES     = 110;
  localparam int LONG_HOLD        = 600;
  localparam int QUIET_LIMIT      = 4000;
  localparam int SETTLE_CYCLES    = 110;

  typedef struct packed {
    logic [TS_W-1:0] start_ms;
    logic [TS_W-1:0] end_ms;
  } frame_t;

  typedef struct packed {
    logic [Q_W-1:0]     fps_q8;
    logic [Q_W-1:0]     avg_interval_q8;
    logic [DELAY_W-1:0] delay_ms;
  } rate_report_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_wen;
  logic [CAP_W-1:0] cfg_wdata;

  frml_in_if  frame_in ();
  frml_out_if result_out ();

  frame_rate_meter_limiter #(.WINDOW(WINDOW)) dut (
    .clk        (clk),
    .rst        (rst),
    .frame_in   (frame_in),
    .result_out (result_out),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  frame_t       frames_to_send [$];
  rate_report_t rate_reports_due [$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_wanted;
  bit          hold_done;
  int          hold_left;
  int          mismatches;
  int          quiet_cycles;

  // Local copy of the meter state and the rate cap register.
  logic [IVL_W-1:0] interval_history [WINDOW];
  logic [47:0]      interval_total;
  int               samples_held;
  int               next_slot;
  logic [TS_W-1:0]  last_end;
  bit               have_last;
  logic [CAP_W-1:0] fps_cap;

  function automatic void clear_meter();
    for (int i = 0; i < WINDOW; i++) interval_history[i] = '0;
    interval_total = '0;
    samples_held   = 0;
    next_slot      = 0;
    last_end       = '0;
    have_last      = 1'b0;
    fps_cap        = '0;
  endfunction

  function automatic rate_report_t meter_frame(logic [TS_W-1:0] s, logic [TS_W-1:0] e);
    rate_report_t     r;
    logic [TS_W-1:0]  gap;
    logic [TS_W-1:0]  span;
    logic [IVL_W-1:0] interval;
    logic [47:0]      avg;
    logic [47:0]      fps;
    int unsigned      cap;
    int unsigned      period;
    interval = '0;
    if (have_last) begin
      gap      = e - last_end;
      interval = (gap > TS_W'(INTERVAL_MAX)) ? INTERVAL_MAX : gap[IVL_W-1:0];
    end
    have_last = 1'b1;
    last_end  = e;

    interval_total = interval_total - 48'(interval_history[next_slot]) + 48'(interval);
    interval_history[next_slot] = interval;
    next_slot = (next_slot + 1 >= WINDOW) ? 0 : next_slot + 1;
    if (samples_held < WINDOW) samples_held++;

    avg = (interval_total << 8) / 48'(samples_held);
    if (avg > 48'(OUT24_MAX)) avg = 48'(OUT24_MAX);
    if (avg == '0) begin
      fps = 48'(DEFAULT_FPS_Q8);
    end else begin
      fps = 48'(FPS_DIVIDEND) / avg;
      if (fps > 48'(OUT24_MAX)) fps = 48'(OUT24_MAX);
    end

    cap    = (fps_cap == '0) ? DEFAULT_FPS : int'(fps_cap);
    period = MS_PER_S / cap;
    span   = e - s;
    r.fps_q8          = fps[Q_W-1:0];
    r.avg_interval_q8 = avg[Q_W-1:0];
    r.delay_ms        = (period > span) ? DELAY_W'(period - span) : '0;
    return r;
  endfunction

  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // The expectation is formed when the frame transfer happens, with the cap then in force.
  always @(posedge clk) begin : drive
    frame_t next_frame;
    if (rst) begin
      frame_in.valid <= 1'b0;
    end else begin
      if (frame_in.valid && frame_in.ready)
        rate_reports_due.push_back(meter_frame(frame_in.start_ms, frame_in.end_ms));
      if (!frame_in.valid || frame_in.ready) begin
        if (frames_to_send.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          next_frame        = frames_to_send.pop_front();
          frame_in.valid    <= 1'b1;
          frame_in.start_ms <= next_frame.start_ms;
          frame_in.end_ms   <= next_frame.end_ms;
        end else begin
          frame_in.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : observe
    rate_report_t want;
    if (rst) begin
      result_out.ready <= 1'b0;
      hold_left        <= 0;
      hold_done        <= 1'b0;
    end else begin
      if (result_out.valid && result_out.ready) begin
        if (rate_reports_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got fps_q8 %0d avg %0d delay %0d",
                   $time, result_out.fps_q8, result_out.avg_interval_q8, result_out.delay_ms);
          mismatches++;
        end else begin
          want = rate_reports_due.pop_front();
          check_field("fps_q8", want.fps_q8, result_out.fps_q8);
          check_field("avg_interval_q8", want.avg_interval_q8, result_out.avg_interval_q8);
          check_field("delay_ms", want.delay_ms, result_out.delay_ms);
        end
      end
      // One long hold-off lets the output register fill and the input back up.
      if (hold_left != 0) begin
        hold_left        <= hold_left - 1;
        result_out.ready <= 1'b0;
      end else if (hold_wanted && !hold_done) begin
        hold_left        <= LONG_HOLD;
        hold_done        <= 1'b1;
        result_out.ready <= 1'b0;
      end else begin
        result_out.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (frame_in.valid && frame_in.ready) || (result_out.valid && result_out.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_frame_rate_meter_limiter: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [TS_W-1:0] stamp;
    logic [TS_W-1:0] stop;
    logic [CAP_W-1:0] cap_plan [PHASES];
    int unsigned send_plan [PHASES];
    int unsigned recv_plan [PHASES];
    int unsigned kind;
    int unsigned span;

    cap_plan  = '{10'd0, 10'd1000, 10'd1, 10'd1023, 10'd60, 10'd0};
    send_plan = '{0, 68, 0, 19, 68, 0};
    recv_plan = '{0, 0, 68, 19, 68, 0};
    cap_plan[PHASES-1] = CAP_W'($urandom_range(1023, 2));

    rst               = 1'b1;
    cfg_wen           = 1'b0;
    cfg_wdata         = '0;
    frame_in.valid    = 1'b0;
    frame_in.start_ms = '0;
    frame_in.end_ms   = '0;
    result_out.ready  = 1'b0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    hold_wanted       = 1'b0;
    mismatches        = 0;
    quiet_cycles      = 0;
    clear_meter();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      @(negedge clk);
      while (frames_to_send.size() != 0 || frame_in.valid || rate_reports_due.size() != 0)
        @(negedge clk);
      repeat (8) @(negedge clk);

      @(posedge clk);
      cfg_wen   <= 1'b1;
      cfg_wdata <= cap_plan[p];
      fps_cap    = cap_plan[p];
      @(posedge clk);
      cfg_wen <= 1'b0;

      @(negedge clk);
      send_idle_pct  = send_plan[p];
      recv_stall_pct = recv_plan[p];

      if (p == 0) begin
        // First frame, wrap of both differences, exact saturation edges, bit patterns.
        frames_to_send.push_back('{32'h0000_0000, 32'h0000_0000});
        frames_to_send.push_back('{32'hFFFF_FFF0, 32'hFFFF_FFFF});
        frames_to_send.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF});
        frames_to_send.push_back('{32'hFFFF_FFFF, 32'h0000_0000});
        frames_to_send.push_back('{32'h0000_0000, 32'h0000_0010});
        frames_to_send.push_back('{32'h0000_0014, 32'h0000_000A});
        frames_to_send.push_back('{32'd70000, 32'd70010});
        frames_to_send.push_back('{32'd135545, 32'd135545});
        frames_to_send.push_back('{32'd201080, 32'd201081});
        frames_to_send.push_back('{32'd201081, 32'd201082});
        frames_to_send.push_back('{32'hAAAA_AAAA, 32'h5555_5555});
        frames_to_send.push_back('{32'h5555_5555, 32'hAAAA_AAAA});
        frames_to_send.push_back('{32'h0000_0000, 32'h8000_0000});
        frames_to_send.push_back('{32'h8000_0000, 32'h8000_000F});
        for (int i = 0; i < 5; i++)
          frames_to_send.push_back('{32'h8000_0010 + 16 * i, 32'h8000_001F + 16 * i});
        stamp = 32'h8000_005F;
        hold_wanted = 1'b1;
      end else begin
        stamp = $urandom;
      end

      // A still scene drives the average to zero, then a single 1 ms step makes it tiny.
      if (p == 1 || p == 3) begin
        for (int i = 0; i < STILL_FRAMES; i++)
          frames_to_send.push_back('{stamp - $urandom_range(3, 0), stamp});
        stamp = stamp + 1;
        for (int i = 0; i < 20; i++)
          frames_to_send.push_back('{stamp, stamp});
      end

      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        kind = $urandom_range(99, 0);
        if (kind < 60) begin
          stop = stamp + $urandom_range(45, 5);
          span = $urandom_range(40, 0);
          frames_to_send.push_back('{stop - span, stop});
        end else if (kind < 70) begin
          stop = stamp + $urandom_range(2, 0);
          frames_to_send.push_back('{stop - $urandom_range(3, 0), stop});
        end else if (kind < 78) begin
          stop = stamp + $urandom_range(200000, 60000);
          frames_to_send.push_back('{stop - $urandom_range(1100, 0), stop});
        end else if (kind < 86) begin
          stop = stamp - $urandom_range(5000, 1);
          frames_to_send.push_back('{stop + $urandom_range(30, 0), stop});
        end else begin
          stop = $urandom;
          frames_to_send.push_back('{$urandom, stop});
        end
        stamp = stop;
      end
    end

    @(negedge clk);
    while (frames_to_send.size() != 0 || frame_in.valid || rate_reports_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (mismatches == 0 && rate_reports_due.size() == 0)
      $display("tb_frame_rate_meter_limiter: clean");
    else
      $display("tb_frame_rate_meter_limiter: errors");
    $finish;
  end

endmodule
